// ----- rtl/mbe_pkg.sv -----
// Shared types and constants of the Mandelbrot escape-time evaluator.
`default_nettype none

package mbe_pkg;

    // Image size that sets the mapping origin (pixel minus half size).
    localparam int unsigned IMAGE_WIDTH  = 800;
    localparam int unsigned IMAGE_HEIGHT = 600;
    localparam logic [10:0] HALF_W = 11'(IMAGE_WIDTH / 2);
    localparam logic [10:0] HALF_H = 11'(IMAGE_HEIGHT / 2);

    // Signed Q4.60 constants.
    localparam logic [63:0] Q_MAX            = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] Q_MIN            = 64'h8000_0000_0000_0000;
    localparam logic [63:0] ONE_Q60          = 64'h1000_0000_0000_0000;
    localparam logic [63:0] NEG_ONE_Q60      = 64'hF000_0000_0000_0000;
    localparam logic [63:0] NEG_TWO_Q60      = 64'hE000_0000_0000_0000;
    localparam logic [63:0] QUARTER_Q60      = 64'h0400_0000_0000_0000;
    localparam logic [63:0] THREE_16THS_Q60  = 64'h0300_0000_0000_0000;
    localparam logic [63:0] SIXTEENTH_Q60    = 64'h0100_0000_0000_0000;

    // Register reset values.
    localparam logic [63:0] CENTER_RE_RST  = 64'hF800_0000_0000_0000;
    localparam logic [63:0] CENTER_IM_RST  = 64'h0000_0000_0000_0000;
    localparam logic [62:0] PIXEL_STEP_RST = 63'd5697138765606096;
    localparam logic [15:0] MAX_ITER_RST   = 16'd45;

    typedef struct packed {
        logic [9:0] pixel_x;
        logic [9:0] pixel_y;
    } t_in_item;

    typedef struct packed {
        logic [9:0]  out_x;
        logic [9:0]  out_y;
        logic [16:0] iter_count;
        logic        in_set;
        logic [31:0] escape_mag_sq;
    } t_out_item;

    // Products the shared multiplier can be asked for.
    typedef enum logic [2:0] {
        MOP_MAP_RE,
        MOP_MAP_IM,
        MOP_XX,
        MOP_YY,
        MOP_XY,
        MOP_AA,
        MOP_BB,
        MOP_QR
    } t_mul_op;

    typedef struct packed {
        logic    load_pix;
        logic    mul_issue;
        t_mul_op mul_op;
        logic    map_done;
        logic    card_prep;
        logic    card_decide;
        logic    eval;
        logic    update;
    } t_dp_cmd;

    typedef struct packed {
        logic mul_busy;
        logic go;
    } t_dp_stat;

endpackage

`default_nettype wire

// ----- rtl/mbe_mul.sv -----
// Pipelined signed 64x64 multiplier built from four 32x32 partial products.
`default_nettype none

module mbe_mul
    import mbe_pkg::*;
(
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_issue,
    input  wire logic [1:0]   i_tag,
    input  wire logic [63:0]  i_a,
    input  wire logic [63:0]  i_b,
    output logic              o_busy,
    output logic              o_wb_valid,
    output logic [1:0]        o_wb_tag,
    output logic [127:0]      o_wb_prod
);

    logic         r_v1, r_v2, r_v3;
    logic [1:0]   r_t1, r_t2, r_t3;
    logic         r_neg1, r_neg2, r_neg3;
    logic [63:0]  r_ma, r_mb;
    logic [63:0]  r_p00, r_p01, r_p10, r_p11;
    logic [127:0] r_mag;

    logic [63:0]  n_ma, n_mb;

    assign n_ma = i_a[63] ? (~i_a + 64'd1) : i_a;
    assign n_mb = i_b[63] ? (~i_b + 64'd1) : i_b;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            r_v1 <= i_issue;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ma   <= n_ma;
        r_mb   <= n_mb;
        r_neg1 <= i_a[63] ^ i_b[63];
        r_t1   <= i_tag;

        r_p00  <= {32'b0, r_ma[31:0]}  * {32'b0, r_mb[31:0]};
        r_p01  <= {32'b0, r_ma[31:0]}  * {32'b0, r_mb[63:32]};
        r_p10  <= {32'b0, r_ma[63:32]} * {32'b0, r_mb[31:0]};
        r_p11  <= {32'b0, r_ma[63:32]} * {32'b0, r_mb[63:32]};
        r_neg2 <= r_neg1;
        r_t2   <= r_t1;

        r_mag  <= {r_p11, r_p00} + {32'b0, r_p01, 32'b0} + {32'b0, r_p10, 32'b0};
        r_neg3 <= r_neg2;
        r_t3   <= r_t2;
    end

    assign o_busy     = r_v1 | r_v2 | r_v3;
    assign o_wb_valid = r_v3;
    assign o_wb_tag   = r_t3;
    assign o_wb_prod  = r_neg3 ? (~r_mag + 128'd1) : r_mag;

endmodule

`default_nettype wire

// ----- rtl/mbe_datapath.sv -----
// Datapath: coordinate mapping, cardioid and bulb test, z iteration registers.
`default_nettype none

module mbe_datapath
    import mbe_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire t_dp_cmd     i_cmd,
    output t_dp_stat         o_stat,
    input  wire t_in_item    i_in,
    input  wire logic [63:0] i_center_re,
    input  wire logic [63:0] i_center_im,
    input  wire logic [62:0] i_pixel_step,
    input  wire logic [15:0] i_max_iter,
    output t_out_item        o_result
);

    function automatic logic [63:0] sat_shr(input logic [127:0] p, input int unsigned sh);
        logic [127:0] t;
        t = 128'($signed(p) >>> sh);
        if ((&t[127:63]) || !(|t[127:63])) begin
            sat_shr = t[63:0];
        end else if (t[127]) begin
            sat_shr = Q_MIN;
        end else begin
            sat_shr = Q_MAX;
        end
    endfunction

    function automatic logic [63:0] sat65(input logic [64:0] s);
        if (s[64] == s[63]) begin
            sat65 = s[63:0];
        end else if (s[64]) begin
            sat65 = Q_MIN;
        end else begin
            sat65 = Q_MAX;
        end
    endfunction

    logic [9:0]   r_px, r_py;
    logic [63:0]  r_cr, r_ci, r_zr, r_zi;
    logic [63:0]  r_a, r_b, r_q, r_r, r_y2c, r_dxy, r_xy2;
    logic [127:0] r_p0, r_p1, r_p2, r_p3;
    logic         r_win, r_bulb, r_forced, r_go;
    logic [16:0]  r_n;
    logic [31:0]  r_mag;

    logic [10:0]  dx, dy;
    logic [63:0]  mul_a, mul_b;
    logic [1:0]   mul_tag;
    logic         mul_busy, wb_valid;
    logic [1:0]   wb_tag;
    logic [127:0] wb_prod;

    logic [63:0]  x2, y2, a2, b2;
    logic [127:0] sum_sq, map_re, map_im;
    logic         win, shape;

    assign dx = {1'b0, r_px} - HALF_W;
    assign dy = {1'b0, r_py} - HALF_H;

    always_comb begin
        mul_a   = '0;
        mul_b   = '0;
        mul_tag = 2'd0;
        case (i_cmd.mul_op)
            MOP_MAP_RE: begin
                mul_a   = {{53{dx[10]}}, dx};
                mul_b   = {1'b0, i_pixel_step};
                mul_tag = 2'd0;
            end
            MOP_MAP_IM: begin
                mul_a   = {{53{dy[10]}}, dy};
                mul_b   = {1'b0, i_pixel_step};
                mul_tag = 2'd1;
            end
            MOP_XX: begin
                mul_a   = r_zr;
                mul_b   = r_zr;
                mul_tag = 2'd0;
            end
            MOP_YY: begin
                mul_a   = r_zi;
                mul_b   = r_zi;
                mul_tag = 2'd1;
            end
            MOP_XY: begin
                mul_a   = r_zr;
                mul_b   = r_zi;
                mul_tag = 2'd2;
            end
            MOP_AA: begin
                mul_a   = r_a;
                mul_b   = r_a;
                mul_tag = 2'd2;
            end
            MOP_BB: begin
                mul_a   = r_b;
                mul_b   = r_b;
                mul_tag = 2'd3;
            end
            MOP_QR: begin
                mul_a   = r_q;
                mul_b   = r_r;
                mul_tag = 2'd0;
            end
            default: begin
                mul_a   = '0;
                mul_b   = '0;
                mul_tag = 2'd0;
            end
        endcase
    end

    mbe_mul u_mul (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_issue    (i_cmd.mul_issue),
        .i_tag      (mul_tag),
        .i_a        (mul_a),
        .i_b        (mul_b),
        .o_busy     (mul_busy),
        .o_wb_valid (wb_valid),
        .o_wb_tag   (wb_tag),
        .o_wb_prod  (wb_prod)
    );

    // Products brought back to Q4.60 with saturation.
    assign x2 = sat_shr(r_p0, 60);
    assign y2 = sat_shr(r_p1, 60);
    assign a2 = sat_shr(r_p2, 60);
    assign b2 = sat_shr(r_p3, 60);

    assign map_re = r_p0 + {{64{i_center_re[63]}}, i_center_re};
    assign map_im = r_p1 + {{64{i_center_im[63]}}, i_center_im};

    // Both shapes lie inside -2 <= re < 1, -1 < im < 1.
    assign win = !($signed(r_cr) < $signed(NEG_TWO_Q60)) &&
                 ($signed(r_cr) < $signed(ONE_Q60)) &&
                 ($signed(NEG_ONE_Q60) < $signed(r_ci)) &&
                 ($signed(r_ci) < $signed(ONE_Q60));

    // Cardioid: q*r < y^2/4, compared at Q8.120.
    assign shape = r_win && (($signed(r_p0) < $signed({6'b0, r_y2c, 58'b0})) || r_bulb);

    assign sum_sq = r_p0 + r_p1;

    always_ff @(posedge i_clk) begin
        r_a <= r_cr - QUARTER_Q60;
        r_b <= r_cr + ONE_Q60;

        if (i_cmd.load_pix) begin
            r_px <= i_in.pixel_x;
            r_py <= i_in.pixel_y;
        end

        if (wb_valid) begin
            case (wb_tag)
                2'd0:    r_p0 <= wb_prod;
                2'd1:    r_p1 <= wb_prod;
                2'd2:    r_p2 <= wb_prod;
                default: r_p3 <= wb_prod;
            endcase
        end

        if (i_cmd.map_done) begin
            r_cr <= sat_shr(map_re, 0);
            r_ci <= sat_shr(map_im, 0);
            r_zr <= sat_shr(map_re, 0);
            r_zi <= sat_shr(map_im, 0);
        end

        if (i_cmd.card_prep) begin
            r_q    <= a2 + y2;
            r_r    <= x2 + {r_cr[63], r_cr[63:1]} + y2 - THREE_16THS_Q60;
            r_y2c  <= y2;
            r_bulb <= $signed(b2 + y2) < $signed(SIXTEENTH_Q60);
            r_win  <= win;
        end

        if (i_cmd.card_decide) begin
            r_forced <= shape;
            r_n      <= shape ? {1'b0, i_max_iter} : 17'd0;
        end

        if (i_cmd.eval) begin
            r_go  <= !r_forced && (r_n <= {1'b0, i_max_iter}) && (sum_sq[127:122] == 6'd0);
            r_mag <= (|sum_sq[127:126]) ? 32'hFFFF_FFFF : sum_sq[125:94];
            r_dxy <= x2 - y2;
            r_xy2 <= sat_shr(r_p2, 59);
        end

        if (i_cmd.update) begin
            r_zr <= sat65({r_dxy[63], r_dxy} + {r_cr[63], r_cr});
            r_zi <= sat65({r_xy2[63], r_xy2} + {r_ci[63], r_ci});
            r_n  <= r_n + 17'd1;
        end
    end

    assign o_stat.mul_busy = mul_busy;
    assign o_stat.go       = r_go;

    assign o_result.out_x         = r_px;
    assign o_result.out_y         = r_py;
    assign o_result.iter_count    = r_n;
    assign o_result.in_set        = r_n >= {1'b0, i_max_iter};
    assign o_result.escape_mag_sq = r_mag;

endmodule

`default_nettype wire

// ----- rtl/mbe_ctrl.sv -----
// Controller: sequences multiplies and datapath steps for one pixel.
`default_nettype none

module mbe_ctrl
    import mbe_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_in_valid,
    input  wire logic     i_out_free,
    input  wire t_dp_stat i_stat,
    output t_dp_cmd       o_cmd,
    output logic          o_in_stall,
    output logic          o_finish
);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MAP_ISSUE,
        ST_MAP_WAIT,
        ST_MAP_ADD,
        ST_CARD_ISSUE,
        ST_CARD_WAIT,
        ST_CARD_PREP,
        ST_QR_ISSUE,
        ST_QR_WAIT,
        ST_CARD_DECIDE,
        ST_LOOP_ISSUE,
        ST_LOOP_WAIT,
        ST_EVAL,
        ST_STEP,
        ST_FINISH
    } t_state;

    t_state     r_state;
    logic [1:0] r_cnt;

    always_comb begin
        o_cmd        = '0;
        o_cmd.mul_op = MOP_MAP_RE;
        o_finish     = 1'b0;
        case (r_state)
            ST_IDLE:        o_cmd.load_pix = i_in_valid;
            ST_MAP_ISSUE: begin
                o_cmd.mul_issue = 1'b1;
                o_cmd.mul_op    = r_cnt[0] ? MOP_MAP_IM : MOP_MAP_RE;
            end
            ST_MAP_ADD:     o_cmd.map_done = 1'b1;
            ST_CARD_ISSUE: begin
                o_cmd.mul_issue = 1'b1;
                case (r_cnt)
                    2'd0:    o_cmd.mul_op = MOP_XX;
                    2'd1:    o_cmd.mul_op = MOP_YY;
                    2'd2:    o_cmd.mul_op = MOP_AA;
                    default: o_cmd.mul_op = MOP_BB;
                endcase
            end
            ST_CARD_PREP:   o_cmd.card_prep = 1'b1;
            ST_QR_ISSUE: begin
                o_cmd.mul_issue = 1'b1;
                o_cmd.mul_op    = MOP_QR;
            end
            ST_CARD_DECIDE: o_cmd.card_decide = 1'b1;
            ST_LOOP_ISSUE: begin
                o_cmd.mul_issue = 1'b1;
                case (r_cnt)
                    2'd0:    o_cmd.mul_op = MOP_XX;
                    2'd1:    o_cmd.mul_op = MOP_YY;
                    default: o_cmd.mul_op = MOP_XY;
                endcase
            end
            ST_EVAL:        o_cmd.eval = 1'b1;
            ST_STEP:        o_cmd.update = i_stat.go;
            ST_FINISH:      o_finish = i_out_free;
            default:        o_cmd.mul_issue = 1'b0;
        endcase
    end

    assign o_in_stall = (r_state != ST_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_cnt   <= 2'd0;
        end else begin
            case (r_state)
                ST_IDLE: begin
                    r_cnt <= 2'd0;
                    if (i_in_valid) begin
                        r_state <= ST_MAP_ISSUE;
                    end
                end
                ST_MAP_ISSUE: begin
                    if (r_cnt == 2'd1) begin
                        r_cnt   <= 2'd0;
                        r_state <= ST_MAP_WAIT;
                    end else begin
                        r_cnt <= r_cnt + 2'd1;
                    end
                end
                ST_MAP_WAIT: begin
                    if (!i_stat.mul_busy) begin
                        r_state <= ST_MAP_ADD;
                    end
                end
                ST_MAP_ADD:     r_state <= ST_CARD_ISSUE;
                ST_CARD_ISSUE: begin
                    r_cnt <= r_cnt + 2'd1;
                    if (r_cnt == 2'd3) begin
                        r_state <= ST_CARD_WAIT;
                    end
                end
                ST_CARD_WAIT: begin
                    if (!i_stat.mul_busy) begin
                        r_state <= ST_CARD_PREP;
                    end
                end
                ST_CARD_PREP:   r_state <= ST_QR_ISSUE;
                ST_QR_ISSUE:    r_state <= ST_QR_WAIT;
                ST_QR_WAIT: begin
                    if (!i_stat.mul_busy) begin
                        r_state <= ST_CARD_DECIDE;
                    end
                end
                ST_CARD_DECIDE: begin
                    r_cnt   <= 2'd0;
                    r_state <= ST_LOOP_ISSUE;
                end
                ST_LOOP_ISSUE: begin
                    if (r_cnt == 2'd2) begin
                        r_cnt   <= 2'd0;
                        r_state <= ST_LOOP_WAIT;
                    end else begin
                        r_cnt <= r_cnt + 2'd1;
                    end
                end
                ST_LOOP_WAIT: begin
                    if (!i_stat.mul_busy) begin
                        r_state <= ST_EVAL;
                    end
                end
                ST_EVAL:        r_state <= ST_STEP;
                ST_STEP: begin
                    r_cnt   <= 2'd0;
                    r_state <= i_stat.go ? ST_LOOP_ISSUE : ST_FINISH;
                end
                ST_FINISH: begin
                    if (i_out_free) begin
                        r_state <= ST_IDLE;
                    end
                end
                default:        r_state <= ST_IDLE;
            endcase
        end
    end

endmodule

`default_nettype wire

// ----- rtl/mandelbrot_escape_iteration.sv -----
// Top level: register file, controller, datapath and result register.
//
//  channel  | direction | handshake                    | payload
//  ---------+-----------+------------------------------+---------------------------
//  in       | input     | i_in_valid / o_in_stall      | i_in_data  (t_in_item)
//  out      | output    | o_out_valid / i_out_stall    | o_out_data (t_out_item)
//  config   | input     | psel penable pwrite / pready | paddr, pwdata, prdata (64b)
//
// One pixel at a time: the input stalls until the result is loaded. A cardioid or
// bulb point makes one pass, any other iter_count + 1. A pass is three products
// through the three-stage 64x64 multiplier, a wait for it to drain, then the
// evaluate and step states.
// Synchronous active-low reset restores the register defaults and empties the output.
// A full result register that is not taken holds the block at its last step.
`default_nettype none

module mandelbrot_escape_iteration
    import mbe_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,

    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire t_in_item    i_in_data,

    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output t_out_item        o_out_data,

    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [4:0]  paddr,
    input  wire logic [63:0] pwdata,
    output logic [63:0]      prdata,
    output logic             pready
);

    // Register map: 64-bit registers at byte offsets 8*index.
    typedef enum logic [1:0] {
        REG_CENTER_RE,
        REG_CENTER_IM,
        REG_PIXEL_STEP,
        REG_MAX_ITER
    } t_reg_idx;

    logic [63:0] r_center_re, r_center_im;
    logic [62:0] r_pixel_step;
    logic [15:0] r_max_iter;

    logic        r_out_valid;
    t_out_item   r_out;

    t_reg_idx    reg_idx;
    logic        cfg_write;
    logic        out_free;
    logic        finish;
    t_dp_cmd     dp_cmd;
    t_dp_stat    dp_stat;
    t_out_item   dp_result;

    assign reg_idx   = t_reg_idx'(paddr[4:3]);
    assign cfg_write = psel && penable && pwrite;
    assign pready    = 1'b1;

    // Register writes; the step drops its top bit and the limit keeps 16 bits.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_center_re  <= CENTER_RE_RST;
            r_center_im  <= CENTER_IM_RST;
            r_pixel_step <= PIXEL_STEP_RST;
            r_max_iter   <= MAX_ITER_RST;
        end else if (cfg_write) begin
            case (reg_idx)
                REG_CENTER_RE:  r_center_re  <= pwdata;
                REG_CENTER_IM:  r_center_im  <= pwdata;
                REG_PIXEL_STEP: r_pixel_step <= pwdata[62:0];
                REG_MAX_ITER:   r_max_iter   <= pwdata[15:0];
                default:        r_max_iter   <= r_max_iter;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_CENTER_RE:  prdata = r_center_re;
            REG_CENTER_IM:  prdata = r_center_im;
            REG_PIXEL_STEP: prdata = {1'b0, r_pixel_step};
            REG_MAX_ITER:   prdata = {48'b0, r_max_iter};
            default:        prdata = '0;
        endcase
    end

    // The result register is free when empty or being taken this cycle.
    assign out_free = !r_out_valid || !i_out_stall;

    mbe_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_out_free (out_free),
        .i_stat     (dp_stat),
        .o_cmd      (dp_cmd),
        .o_in_stall (o_in_stall),
        .o_finish   (finish)
    );

    mbe_datapath u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (dp_cmd),
        .o_stat       (dp_stat),
        .i_in         (i_in_data),
        .i_center_re  (r_center_re),
        .i_center_im  (r_center_im),
        .i_pixel_step (r_pixel_step),
        .i_max_iter   (r_max_iter),
        .o_result     (dp_result)
    );

    // Load a finished item, else drop the valid once the item is taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (finish) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (finish) begin
            r_out <= dp_result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

`default_nettype wire

// ----- rtl/mbe_checker.sv -----
// Port-level checks of the escape-time evaluator, bound to the top level.
`default_nettype none

module mbe_port_checker
    import mbe_pkg::*;
(
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_in_valid,
    input wire logic        o_in_stall,
    input wire logic        o_out_valid,
    input wire logic        i_out_stall,
    input wire t_out_item   o_out_data
);

    logic in_acc;

    assign in_acc = i_in_valid && !o_in_stall;

    // Hold a stalled result.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_out_data)))
        else $error("stalled result changed or dropped");

    // One pixel at a time: the input closes right after an item enters.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> o_in_stall)
        else $error("input open while an item is in work");

    // No result can be produced in the cycle right after an item enters.
    a_no_instant_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> !$rose(o_out_valid))
        else $error("result appeared too early");

    // A point outside the set has escaped, so its |z|^2 is at least 4.0.
    a_escape_mag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out_data.in_set) |-> (o_out_data.escape_mag_sq >= 32'h1000_0000))
        else $error("escaped point reports |z|^2 below 4");

endmodule

bind mandelbrot_escape_iteration mbe_port_checker u_mbe_checker (.*);

`default_nettype wire
